// ===== rtl/vurm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vurm_pkg
// Shared types, offsets and reset values of the virtual UART register model.
// ----------------------------------------------------------------------------
package vurm_pkg;

    // Receive ring
    localparam int RX_DEPTH   = 256;
    localparam int RX_ADDR_W  = $clog2(RX_DEPTH);
    localparam int RX_PTR_W   = $clog2(2 * RX_DEPTH);

    // Item field widths
    localparam int MODE_W     = 2;
    localparam int OFFSET_W   = 12;
    localparam int DATA_W     = 32;
    localparam int CHAR_W     = 8;
    localparam int IRQ_W      = 13;

    // Register window
    localparam int NWORDS     = 18;
    localparam int WORD_IDX_W = $clog2(NWORDS);

    typedef enum logic [MODE_W-1:0] {
        MODE_READ    = 2'd0,
        MODE_WRITE   = 2'd1,
        MODE_RX_CHAR = 2'd2,
        MODE_ACK     = 2'd3
    } mode_t;

    localparam logic [OFFSET_W-1:0] OFF_CONTROL    = 12'h000;
    localparam logic [OFFSET_W-1:0] OFF_MODE       = 12'h004;
    localparam logic [OFFSET_W-1:0] OFF_IRQ_EN     = 12'h008;
    localparam logic [OFFSET_W-1:0] OFF_IRQ_DIS    = 12'h00C;
    localparam logic [OFFSET_W-1:0] OFF_IRQ_STAT   = 12'h014;
    localparam logic [OFFSET_W-1:0] OFF_BAUD_GEN   = 12'h018;
    localparam logic [OFFSET_W-1:0] OFF_RX_TIMEOUT = 12'h01C;
    localparam logic [OFFSET_W-1:0] OFF_RX_TRIGGER = 12'h020;
    localparam logic [OFFSET_W-1:0] OFF_MODEM_CTRL = 12'h024;
    localparam logic [OFFSET_W-1:0] OFF_MODEM_STAT = 12'h028;
    localparam logic [OFFSET_W-1:0] OFF_CHAN_STAT  = 12'h02C;
    localparam logic [OFFSET_W-1:0] OFF_FIFO       = 12'h030;
    localparam logic [OFFSET_W-1:0] OFF_BAUD_DIV   = 12'h034;
    localparam logic [OFFSET_W-1:0] OFF_FLOW_DELAY = 12'h038;
    localparam logic [OFFSET_W-1:0] OFF_TX_TRIGGER = 12'h044;
    localparam logic [OFFSET_W-1:0] WIN_SIZE       = 12'h048;

    localparam logic [WORD_IDX_W-1:0] IDX_IRQ_MASK = 5'd4;
    localparam logic [WORD_IDX_W-1:0] IDX_IRQ_STAT = 5'd5;

    localparam logic [DATA_W-1:0] CR_SELF_CLEAR = 32'h0000_0043;
    localparam logic [IRQ_W-1:0]  ST_RTRIG      = 13'h0001;
    localparam logic [IRQ_W-1:0]  ST_TEMPTY     = 13'h0008;
    localparam logic [DATA_W-1:0] SR_REMPTY     = 32'h0000_0002;
    localparam logic [DATA_W-1:0] SR_TEMPTY     = 32'h0000_0008;
    localparam logic [IRQ_W-1:0]  IRQ_STAT_RST  = 13'h0208;

    localparam logic [DATA_W-1:0] RESET_WORDS [NWORDS] = '{
        32'h0000_0128, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0000_0208,
        32'h0000_028B, 32'h0, 32'h0000_0020, 32'h0, 32'h0, 32'h0,
        32'h0, 32'h0000_000F, 32'h0, 32'h0, 32'h0, 32'h0000_0020
    };

endpackage
`default_nettype wire

// ===== rtl/vurm_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vurm_item_if / vurm_result_if
// Valid/ready channels carrying one input word and one result word.
// ----------------------------------------------------------------------------
interface vurm_item_if;
    logic                          valid;
    logic                          ready;
    logic [vurm_pkg::MODE_W-1:0]   mode;
    logic [vurm_pkg::OFFSET_W-1:0] offset;
    logic [vurm_pkg::DATA_W-1:0]   write_data;
    logic [vurm_pkg::DATA_W-1:0]   byte_mask;
    logic [vurm_pkg::CHAR_W-1:0]   rx_char;

    modport source (output valid, mode, offset, write_data, byte_mask, rx_char,
                    input ready);
    modport sink   (input valid, mode, offset, write_data, byte_mask, rx_char,
                    output ready);
endinterface

interface vurm_result_if;
    logic                          valid;
    logic                          ready;
    logic [vurm_pkg::DATA_W-1:0]   read_data;
    logic                          tx_valid;
    logic [vurm_pkg::CHAR_W-1:0]   tx_char;
    logic                          irq_inject;
    logic                          access_handled;

    modport source (output valid, read_data, tx_valid, tx_char, irq_inject,
                    access_handled, input ready);
    modport sink   (input valid, read_data, tx_valid, tx_char, irq_inject,
                    access_handled, output ready);
endinterface
`default_nettype wire

// ===== rtl/virtual_uart_register_model_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// virtual_uart_register_model_core
// Register window, interrupt logic and receive ring of a virtual UART.
// ----------------------------------------------------------------------------
// Pipeline: an accepted word goes through the state stage, then the output
//   register; the ring RAM read lands in between.
// Throughput: one word per cycle while result.ready does not hold the output back.
// Reset: registers return to their reset values, ring pointers clear and the
//   ring is empty; ring RAM contents are left as they are (no clearing pass).
// ----------------------------------------------------------------------------
module virtual_uart_register_model_core (
    input  wire logic clk,
    input  wire logic rst_n,
    vurm_item_if.sink     item,
    vurm_result_if.source result
);

    localparam int PTR_W  = vurm_pkg::RX_PTR_W;
    localparam int ADDR_W = vurm_pkg::RX_ADDR_W;
    localparam logic [PTR_W:0]   SPAN    = (PTR_W+1)'(2 * vurm_pkg::RX_DEPTH);
    localparam logic [PTR_W-1:0] DEPTH_P = PTR_W'(vurm_pkg::RX_DEPTH);
    localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(2 * vurm_pkg::RX_DEPTH - 1);

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        return (p == PTR_MAX) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [ADDR_W-1:0] ring_index(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        q = (p >= DEPTH_P) ? p - DEPTH_P : p;
        return q[ADDR_W-1:0];
    endfunction

    // architectural state
    logic [vurm_pkg::DATA_W-1:0] words_reg [vurm_pkg::NWORDS];
    logic [vurm_pkg::DATA_W-1:0] words_next [vurm_pkg::NWORDS];
    logic [vurm_pkg::IRQ_W-1:0]  stat_reg, stat_next;
    logic [vurm_pkg::IRQ_W-1:0]  mask_reg, mask_next;
    logic [PTR_W-1:0]            wptr_reg, wptr_next;
    logic [PTR_W-1:0]            rptr_reg, rptr_next;
    logic                        pend_reg, pend_next;

    // state stage
    logic                        s1_valid_reg;
    logic [vurm_pkg::DATA_W-1:0] s1_rd_reg, s1_rd_next;
    logic                        s1_pop_reg, s1_pop_next;
    logic                        s1_txv_reg, s1_txv_next;
    logic [vurm_pkg::CHAR_W-1:0] s1_txc_reg, s1_txc_next;
    logic                        s1_inj_reg, s1_inj_next;
    logic                        s1_ok_reg, s1_ok_next;

    // output register
    logic                        out_valid_reg;
    logic [vurm_pkg::DATA_W-1:0] out_rd_reg;
    logic                        out_txv_reg;
    logic [vurm_pkg::CHAR_W-1:0] out_txc_reg;
    logic                        out_inj_reg;
    logic                        out_ok_reg;

    logic                        accept;
    logic                        out_move;
    logic                        s1_move;
    logic [PTR_W:0]              cnt_wide;
    logic [PTR_W-1:0]            cnt;
    logic [vurm_pkg::DATA_W-1:0] d;
    logic [vurm_pkg::WORD_IDX_W-1:0] idx;
    logic                        ram_we, ram_re;
    logic [vurm_pkg::CHAR_W-1:0] ram_q;
    vurm_pkg::mode_t             mode;

    assign out_move    = !out_valid_reg || result.ready;
    assign s1_move     = s1_valid_reg && out_move;
    assign item.ready  = !s1_valid_reg || out_move;
    assign accept      = item.valid && item.ready;

    assign cnt_wide = {1'b0, wptr_reg} + ((wptr_reg >= rptr_reg) ? '0 : SPAN)
                      - {1'b0, rptr_reg};
    assign cnt      = cnt_wide[PTR_W-1:0];
    assign d        = item.write_data & item.byte_mask;
    assign idx      = item.offset[vurm_pkg::WORD_IDX_W+1:2];
    assign mode     = vurm_pkg::mode_t'(item.mode);

    always_comb
    begin
        words_next  = words_reg;
        stat_next   = stat_reg;
        mask_next   = mask_reg;
        wptr_next   = wptr_reg;
        rptr_next   = rptr_reg;
        pend_next   = pend_reg;
        s1_rd_next  = '0;
        s1_pop_next = 1'b0;
        s1_txv_next = 1'b0;
        s1_txc_next = '0;
        s1_inj_next = 1'b0;
        s1_ok_next  = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        unique case (mode)
            vurm_pkg::MODE_READ:
            begin
                if (item.offset < vurm_pkg::WIN_SIZE)
                begin
                    s1_ok_next = 1'b1;
                    if (item.offset == vurm_pkg::OFF_CHAN_STAT)
                    begin
                        s1_rd_next = vurm_pkg::SR_TEMPTY
                                   | ((cnt == '0) ? vurm_pkg::SR_REMPTY : '0);
                    end
                    else if (item.offset == vurm_pkg::OFF_IRQ_STAT)
                    begin
                        s1_rd_next = {{(vurm_pkg::DATA_W-vurm_pkg::IRQ_W){1'b0}}, stat_reg};
                    end
                    else if (item.offset == vurm_pkg::OFF_FIFO)
                    begin
                        // pop: the RAM registers the read data, which joins the state stage
                        if (cnt != '0)
                        begin
                            ram_re      = 1'b1;
                            s1_pop_next = 1'b1;
                            rptr_next   = ptr_next(rptr_reg);
                        end
                        if (cnt == PTR_W'(1))
                        begin
                            stat_next = stat_reg & ~vurm_pkg::ST_RTRIG;
                        end
                    end
                    else if (idx == vurm_pkg::IDX_IRQ_MASK)
                    begin
                        s1_rd_next = {{(vurm_pkg::DATA_W-vurm_pkg::IRQ_W){1'b0}}, mask_reg};
                    end
                    else if (idx == vurm_pkg::IDX_IRQ_STAT)
                    begin
                        s1_rd_next = {{(vurm_pkg::DATA_W-vurm_pkg::IRQ_W){1'b0}}, stat_reg};
                    end
                    else
                    begin
                        s1_rd_next = words_reg[idx];
                    end
                end
            end
            vurm_pkg::MODE_WRITE:
            begin
                s1_ok_next = 1'b1;
                unique case (item.offset)
                    vurm_pkg::OFF_IRQ_EN:
                        mask_next = mask_reg | d[vurm_pkg::IRQ_W-1:0];
                    vurm_pkg::OFF_IRQ_DIS:
                        mask_next = mask_reg & ~d[vurm_pkg::IRQ_W-1:0];
                    vurm_pkg::OFF_IRQ_STAT:
                        stat_next = (stat_reg & ~d[vurm_pkg::IRQ_W-1:0])
                                  | vurm_pkg::ST_TEMPTY;
                    vurm_pkg::OFF_CONTROL:
                        words_next[0] = ((words_reg[0] & ~item.byte_mask) | d)
                                      & ~vurm_pkg::CR_SELF_CLEAR;
                    vurm_pkg::OFF_MODE, vurm_pkg::OFF_BAUD_GEN,
                    vurm_pkg::OFF_RX_TIMEOUT, vurm_pkg::OFF_RX_TRIGGER,
                    vurm_pkg::OFF_MODEM_CTRL, vurm_pkg::OFF_MODEM_STAT,
                    vurm_pkg::OFF_BAUD_DIV, vurm_pkg::OFF_FLOW_DELAY,
                    vurm_pkg::OFF_TX_TRIGGER:
                        words_next[idx] = (words_reg[idx] & ~item.byte_mask) | d;
                    vurm_pkg::OFF_FIFO:
                    begin
                        s1_txv_next = 1'b1;
                        s1_txc_next = item.write_data[vurm_pkg::CHAR_W-1:0];
                    end
                    default:
                        s1_ok_next = 1'b0;
                endcase
            end
            vurm_pkg::MODE_RX_CHAR:
            begin
                s1_ok_next = 1'b1;
                // drop the character when the ring is full
                if (cnt < DEPTH_P)
                begin
                    ram_we    = 1'b1;
                    wptr_next = ptr_next(wptr_reg);
                end
                stat_next = stat_reg | vurm_pkg::ST_RTRIG;
                if (!pend_reg)
                begin
                    pend_next   = 1'b1;
                    s1_inj_next = 1'b1;
                end
            end
            vurm_pkg::MODE_ACK:
            begin
                s1_ok_next = 1'b1;
                if ((stat_reg & mask_reg) != '0)
                begin
                    s1_inj_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end
            default:
            begin
                s1_ok_next = 1'b0;
            end
        endcase
        if (!accept)
        begin
            ram_we = 1'b0;
            ram_re = 1'b0;
        end
    end

    vurm_ram #(
        .WIDTH (vurm_pkg::CHAR_W),
        .DEPTH (vurm_pkg::RX_DEPTH)
    ) u_rx_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ring_index(wptr_reg)),
        .wdata (item.rx_char),
        .re    (ram_re),
        .raddr (ring_index(rptr_reg)),
        .rdata (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < vurm_pkg::NWORDS; i++)
            begin
                words_reg[i] <= vurm_pkg::RESET_WORDS[i];
            end
            stat_reg      <= vurm_pkg::IRQ_STAT_RST;
            mask_reg      <= '0;
            wptr_reg      <= '0;
            rptr_reg      <= '0;
            pend_reg      <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                words_reg <= words_next;
                stat_reg  <= stat_next;
                mask_reg  <= mask_next;
                wptr_reg  <= wptr_next;
                rptr_reg  <= rptr_next;
                pend_reg  <= pend_next;
            end
            if (item.ready)
            begin
                s1_valid_reg <= item.valid;
            end
            if (out_move)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_rd_reg  <= s1_rd_next;
            s1_pop_reg <= s1_pop_next;
            s1_txv_reg <= s1_txv_next;
            s1_txc_reg <= s1_txc_next;
            s1_inj_reg <= s1_inj_next;
            s1_ok_reg  <= s1_ok_next;
        end
        if (s1_move)
        begin
            out_rd_reg  <= s1_pop_reg ? {{(vurm_pkg::DATA_W-vurm_pkg::CHAR_W){1'b0}}, ram_q}
                                      : s1_rd_reg;
            out_txv_reg <= s1_txv_reg;
            out_txc_reg <= s1_txc_reg;
            out_inj_reg <= s1_inj_reg;
            out_ok_reg  <= s1_ok_reg;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.read_data      = out_rd_reg;
    assign result.tx_valid       = out_txv_reg;
    assign result.tx_char        = out_txc_reg;
    assign result.irq_inject     = out_inj_reg;
    assign result.access_handled = out_ok_reg;

    // ring never holds more than its depth
    a_ring_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt <= DEPTH_P)
        else $error("receive ring count exceeds depth");

    // a host character always leaves an interrupt pending
    a_rx_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && mode == vurm_pkg::MODE_RX_CHAR) |=> pend_reg)
        else $error("interrupt not pending after host character");

    // an ignored access neither transmits nor injects
    a_ignored_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ok_reg) |-> (!out_txv_reg && !out_inj_reg))
        else $error("ignored access produced a side effect");

    // a pop reads the ring only when it holds a character
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |-> (cnt != '0 && !ram_we))
        else $error("ring read while empty");

endmodule
`default_nettype wire

// ===== rtl/vurm_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vurm_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module vurm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // hold read data until the next read
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire
